// ===== rtl/vcsp_pkg.sv =====
package vcsp_pkg;

   // Chunk identifiers as little-endian words.
   localparam logic [31:0] ID_VOX  = 32'h2058_4F56;
   localparam logic [31:0] ID_SIZE = 32'h455A_4953;
   localparam logic [31:0] ID_XYZI = 32'h495A_5958;
   localparam logic [31:0] ID_RGBA = 32'h4142_4752;

   localparam logic [31:0] PALETTE_BYTES = 32'd1024;
   localparam logic [31:0] MAX_COUNT     = 32'd16777216;
   localparam int          DEF_MAX_DIM   = 256;

   localparam int DIM_W   = 9;
   localparam int SLOT_W  = 8;
   localparam int PAL_W   = 32;
   localparam int STAT_W  = 3;
   localparam int KIND_W  = 2;
   localparam int DATA_W  = 72;
   localparam int COUNT_W = 25;

   localparam logic [KIND_W-1:0] KIND_DIMS    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VOXEL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PALETTE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_MAGIC   = 3'd1;
   localparam logic [STAT_W-1:0] ST_OVERRUN = 3'd2;
   localparam logic [STAT_W-1:0] ST_SIZE    = 3'd3;
   localparam logic [STAT_W-1:0] ST_COUNT   = 3'd4;
   localparam logic [STAT_W-1:0] ST_VOXEL   = 3'd5;
   localparam logic [STAT_W-1:0] ST_PALETTE = 3'd6;
   localparam logic [STAT_W-1:0] ST_MISSING = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DIM_W-1:0]  pos_x;
      logic [DIM_W-1:0]  pos_y;
      logic [DIM_W-1:0]  pos_z;
      logic [SLOT_W-1:0] slot;
      logic [PAL_W-1:0]  pal;
      logic [STAT_W-1:0] status;
      logic              eof;
   } result_type;

endpackage

// ===== rtl/vox_chunk_stream_parser.sv =====
// A result is registered into the result queue when the byte that completes its word is taken.
// Throughput: one byte per cycle while the result queue holds at most one entry; a byte
// that yields both a data word and the end status fills two slots of the three-entry result queue, so ready drops.
// Reset: synchronous, active high; returns the parser to the magic phase with an
// empty result queue. After every last byte the parser also returns to the magic phase, with its end status queued.
module vox_chunk_stream_parser #(
   parameter int MAX_DIM = vcsp_pkg::DEF_MAX_DIM
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pos_x[8:0], pos_y[17:9], pos_z[26:18], color_slot[34:27],
   // palette_value[66:35], status_code[69:67], zero[71:70]
   output logic [vcsp_pkg::DATA_W-1:0] rsp_tdata,
   output logic [vcsp_pkg::KIND_W-1:0] rsp_tuser, // item_kind
   output logic        rsp_tlast    // end_of_file
);
   import vcsp_pkg::*;

   typedef enum logic [3:0] {
      PH_MAGIC, PH_VERSION, PH_HDR_ID, PH_HDR_LEN, PH_HDR_CHD,
      PH_SIZE_X, PH_SIZE_Y, PH_SIZE_Z, PH_COUNT, PH_VOXEL,
      PH_PAL, PH_SKIP, PH_SINK
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [1:0]           pos_ff, pos_in;
   logic [23:0]          gather_ff, gather_in;
   logic [31:0]          chunk_ff, chunk_in;
   logic [31:0]          left_ff, left_in;
   logic [COUNT_W-1:0]   vox_ff, vox_in;
   logic [DIM_W-1:0]     dims_ff [3];
   logic [DIM_W-1:0]     dims_in [3];
   logic                 hdims_ff, hdims_in;
   logic                 hvox_ff, hvox_in;
   logic [SLOT_W-1:0]    pidx_ff, pidx_in;
   logic [STAT_W-1:0]    err_ff, err_in;

   result_type           queue_ff [3];
   logic [1:0]           wr_ff, rd_ff, cnt_ff;
   logic [1:0]           wr_in, rd_in, cnt_in;

   logic                 req_accept, pop;
   logic [31:0]          word;
   logic [31:0]          left_dec;
   logic                 data_vld, stat_vld;
   result_type           data_res, stat_res;
   logic [STAT_W-1:0]    stat_code;

   function automatic logic [1:0] ptr_next(input logic [1:0] p);
      return (p == 2'd2) ? 2'd0 : p + 2'd1;
   endfunction

   assign req_tready = (cnt_ff <= 2'd1);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;

   assign word     = {req_tdata, gather_ff};
   assign left_dec = (left_ff != 32'd0) ? left_ff - 32'd1 : left_ff;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      gather_in = gather_ff;
      chunk_in  = chunk_ff;
      left_in   = left_ff;
      vox_in    = vox_ff;
      dims_in   = dims_ff;
      hdims_in  = hdims_ff;
      hvox_in   = hvox_ff;
      pidx_in   = pidx_ff;
      err_in    = err_ff;
      data_vld  = 1'b0;
      data_res  = '0;
      stat_vld  = 1'b0;
      stat_res  = '0;
      stat_code = ST_OK;

      if (req_accept) begin
         if (phase_ff == PH_SKIP) begin
            left_in = left_dec;
            if (left_dec == 32'd0) begin
               phase_in = PH_HDR_ID;
            end
         end else if (phase_ff != PH_SINK) begin
            if (phase_ff >= PH_SIZE_X && phase_ff <= PH_PAL) begin
               left_in = left_dec;
            end
            if (pos_ff == 2'd3) begin
               pos_in    = 2'd0;
               gather_in = '0;
               case (phase_ff)
                  PH_MAGIC: begin
                     if (word != ID_VOX) begin
                        err_in   = ST_MAGIC;
                        phase_in = PH_SINK;
                     end else begin
                        phase_in = PH_VERSION;
                     end
                  end
                  PH_VERSION: phase_in = PH_HDR_ID;
                  PH_HDR_ID: begin
                     chunk_in = word;
                     phase_in = PH_HDR_LEN;
                  end
                  PH_HDR_LEN: begin
                     left_in  = word;
                     phase_in = PH_HDR_CHD;
                  end
                  PH_HDR_CHD: begin
                     if (chunk_ff == ID_SIZE && !hdims_ff) begin
                        if (left_ff < 32'd12) begin
                           err_in   = ST_OVERRUN;
                           phase_in = PH_SINK;
                        end else begin
                           phase_in = PH_SIZE_X;
                        end
                     end else if (chunk_ff == ID_XYZI && hdims_ff && !hvox_ff) begin
                        if (left_ff < 32'd4) begin
                           err_in   = ST_OVERRUN;
                           phase_in = PH_SINK;
                        end else begin
                           phase_in = PH_COUNT;
                        end
                     end else if (chunk_ff == ID_RGBA) begin
                        if (left_ff < PALETTE_BYTES) begin
                           err_in   = ST_PALETTE;
                           phase_in = PH_SINK;
                        end else begin
                           pidx_in  = '0;
                           phase_in = PH_PAL;
                        end
                     end else begin
                        phase_in = (left_ff == 32'd0) ? PH_HDR_ID : PH_SKIP;
                     end
                  end
                  PH_SIZE_X, PH_SIZE_Y, PH_SIZE_Z: begin
                     if (word < 32'd1 || word > 32'(MAX_DIM)) begin
                        err_in   = ST_SIZE;
                        phase_in = PH_SINK;
                     end else if (phase_ff == PH_SIZE_X) begin
                        dims_in[0] = word[DIM_W-1:0];
                        phase_in   = PH_SIZE_Y;
                     end else if (phase_ff == PH_SIZE_Y) begin
                        dims_in[1] = word[DIM_W-1:0];
                        phase_in   = PH_SIZE_Z;
                     end else begin
                        dims_in[2]     = word[DIM_W-1:0];
                        hdims_in       = 1'b1;
                        phase_in       = (left_dec == 32'd0) ? PH_HDR_ID : PH_SKIP;
                        data_vld       = 1'b1;
                        data_res.kind  = KIND_DIMS;
                        data_res.pos_x = dims_ff[0];
                        data_res.pos_y = dims_ff[1];
                        data_res.pos_z = word[DIM_W-1:0];
                     end
                  end
                  PH_COUNT: begin
                     if (word > MAX_COUNT) begin
                        err_in   = ST_COUNT;
                        phase_in = PH_SINK;
                     end else if ({5'd0, word[COUNT_W-1:0], 2'b00} > left_dec) begin
                        err_in   = ST_OVERRUN;
                        phase_in = PH_SINK;
                     end else if (word == 32'd0) begin
                        hvox_in  = 1'b1;
                        phase_in = (left_dec == 32'd0) ? PH_HDR_ID : PH_SKIP;
                     end else begin
                        vox_in   = word[COUNT_W-1:0];
                        phase_in = PH_VOXEL;
                     end
                  end
                  PH_VOXEL: begin
                     if ({1'b0, word[7:0]} >= dims_ff[0] ||
                         {1'b0, word[15:8]} >= dims_ff[1] ||
                         {1'b0, word[23:16]} >= dims_ff[2] ||
                         word[31:24] == 8'd0) begin
                        err_in   = ST_VOXEL;
                        phase_in = PH_SINK;
                     end else begin
                        vox_in = vox_ff - COUNT_W'(1);
                        if (vox_ff == COUNT_W'(1)) begin
                           hvox_in  = 1'b1;
                           phase_in = (left_dec == 32'd0) ? PH_HDR_ID : PH_SKIP;
                        end
                        data_vld       = 1'b1;
                        data_res.kind  = KIND_VOXEL;
                        data_res.pos_x = {1'b0, word[7:0]};
                        data_res.pos_y = {1'b0, word[15:8]};
                        data_res.pos_z = {1'b0, word[23:16]};
                        data_res.slot  = word[31:24];
                     end
                  end
                  PH_PAL: begin
                     data_vld      = 1'b1;
                     data_res.kind = KIND_PALETTE;
                     data_res.slot = pidx_ff;
                     data_res.pal  = word;
                     pidx_in       = pidx_ff + 8'd1;
                     if (pidx_ff == 8'd255) begin
                        phase_in = (left_dec == 32'd0) ? PH_HDR_ID : PH_SKIP;
                     end
                  end
                  default: ;
               endcase
            end else begin
               pos_in = pos_ff + 2'd1;
               case (pos_ff)
                  2'd0:    gather_in[7:0]   = req_tdata;
                  2'd1:    gather_in[15:8]  = req_tdata;
                  default: gather_in[23:16] = req_tdata;
               endcase
            end
         end

         if (req_tlast) begin
            // A file that ends in the magic word or inside owed content is an error;
            // ending inside a header is not, though a missing SIZE or XYZI chunk still is.
            stat_code = err_in;
            if (err_in == ST_OK) begin
               if (phase_in == PH_MAGIC) begin
                  stat_code = ST_MAGIC;
               end else if (phase_in >= PH_SIZE_X && phase_in <= PH_SKIP) begin
                  stat_code = ST_OVERRUN;
               end else if (!hdims_in || !hvox_in) begin
                  stat_code = ST_MISSING;
               end
            end
            stat_vld        = 1'b1;
            stat_res.kind   = KIND_STATUS;
            stat_res.status = stat_code;
            stat_res.eof    = 1'b1;

            phase_in  = PH_MAGIC;
            pos_in    = '0;
            gather_in = '0;
            chunk_in  = '0;
            left_in   = '0;
            vox_in    = '0;
            dims_in   = '{default: '0};
            hdims_in  = 1'b0;
            hvox_in   = 1'b0;
            pidx_in   = '0;
            err_in    = ST_OK;
         end
      end
   end

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = pop ? ptr_next(rd_ff) : rd_ff;
      cnt_in = cnt_ff - {1'b0, pop};
      if (data_vld && stat_vld) begin
         wr_in  = ptr_next(ptr_next(wr_ff));
         cnt_in = cnt_in + 2'd2;
      end else if (data_vld || stat_vld) begin
         wr_in  = ptr_next(wr_ff);
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         pos_ff    <= '0;
         gather_ff <= '0;
         chunk_ff  <= '0;
         left_ff   <= '0;
         vox_ff    <= '0;
         dims_ff   <= '{default: '0};
         hdims_ff  <= 1'b0;
         hvox_ff   <= 1'b0;
         pidx_ff   <= '0;
         err_ff    <= ST_OK;
         wr_ff     <= '0;
         rd_ff     <= '0;
         cnt_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         gather_ff <= gather_in;
         chunk_ff  <= chunk_in;
         left_ff   <= left_in;
         vox_ff    <= vox_in;
         dims_ff   <= dims_in;
         hdims_ff  <= hdims_in;
         hvox_ff   <= hvox_in;
         pidx_ff   <= pidx_in;
         err_ff    <= err_in;
         wr_ff     <= wr_in;
         rd_ff     <= rd_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Result queue: the data word goes first, the end status behind it.
   always_ff @(posedge clock) begin
      if (data_vld) begin
         queue_ff[wr_ff] <= data_res;
         if (stat_vld) begin
            queue_ff[ptr_next(wr_ff)] <= stat_res;
         end
      end else if (stat_vld) begin
         queue_ff[wr_ff] <= stat_res;
      end
   end

   assign rsp_tdata = {2'b00, queue_ff[rd_ff].status, queue_ff[rd_ff].pal,
                       queue_ff[rd_ff].slot, queue_ff[rd_ff].pos_z,
                       queue_ff[rd_ff].pos_y, queue_ff[rd_ff].pos_x};
   assign rsp_tuser = queue_ff[rd_ff].kind;
   assign rsp_tlast = queue_ff[rd_ff].eof;

   a_last_queued: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> cnt_ff != 2'd0)
      else $error("end status not queued after last word");

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> phase_ff == PH_MAGIC && !hdims_ff && !hvox_ff &&
                                  err_ff == ST_OK)
      else $error("parser did not return to the magic phase after last word");

   a_sink_has_error: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SINK |-> err_ff != ST_OK)
      else $error("sink phase without a recorded error");

   a_voxel_ctx: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VOXEL |-> hdims_ff && !hvox_ff && vox_ff != '0)
      else $error("voxel phase without dimensions or with no voxels owed");

endmodule
